[rtl/core/vt4_pkg.sv]
// Package for the 4x4 vertex transform block.
// Holds the queued item type, kind codes and queue sizing; no dependencies.
package vt4_pkg;

  localparam int COMP_W = 32;
  localparam int NUM_COMP = 4;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_XFORM = 1'b1;

  typedef struct packed {
    logic is_load;
    logic [1:0] row;
    logic [NUM_COMP-1:0][COMP_W-1:0] comp;
  } item_t;

endpackage

[rtl/core/vt4_in_if.sv]
// Input channel of the vertex transform block: valid/ready plus item payload.
// No dependencies.
interface vt4_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [1:0] row_index;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;
  logic signed [31:0] comp_w;

  modport source(
    output valid, kind, row_index, comp_x, comp_y, comp_z, comp_w,
    input ready
  );
  modport sink(
    input valid, kind, row_index, comp_x, comp_y, comp_z, comp_w,
    output ready
  );
endinterface

[rtl/core/vt4_out_if.sv]
// Result channel of the vertex transform block: valid/ready plus result payload.
// No dependencies.
interface vt4_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic saturated;

  modport source(
    output valid, out_x, out_y, out_z, out_w, saturated,
    input ready
  );
  modport sink(
    input valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

[rtl/core/vertex_transform_4x4.sv]
// Top level of the 4x4 vertex transform: signed fixed-point M times v.
// Throughput: one item per cycle while the result side is not stalled.
// The 16 multipliers and the row adders feed product, sum and result registers in turn.
// A four-entry queue parts the input side from the arithmetic pipeline.
// Reset is synchronous: queue and pipeline empty, matrix set to the identity.
// Depends on vt4_pkg, vt4_in_if, vt4_out_if, vt4_front and vt4_back.
module vertex_transform_4x4 #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  vt4_in_if.sink    items,
  vt4_out_if.source results
);
  import vt4_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  vt4_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .results (results)
  );

endmodule

[rtl/core/vt4_front.sv]
// Front end: accepts input items, classifies them and queues them in order.
// Depends on vt4_pkg and vt4_in_if.
module vt4_front (
  input  logic           clk,
  input  logic           rst,
  vt4_in_if.sink         items,
  output logic           q_valid,
  output vt4_pkg::item_t q_item,
  input  logic           q_ready
);
  import vt4_pkg::*;

  item_t             queue [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  item_t             item_new;
  logic              push;
  logic              pop;

  always_comb begin
    item_new.is_load = (items.kind == KIND_LOAD);
    item_new.row     = items.row_index;
    item_new.comp[0] = items.comp_x;
    item_new.comp[1] = items.comp_y;
    item_new.comp[2] = items.comp_z;
    item_new.comp[3] = items.comp_w;
  end

  assign items.ready = (count != (QPTR_W+1)'(QDEPTH));
  assign push = items.valid && items.ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= item_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/vt4_back.sv]
// Back end: holds the matrix, applies row loads and runs the three-stage
// multiply, sum and saturate pipeline. Depends on vt4_pkg and vt4_out_if.
module vt4_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  vt4_pkg::item_t q_item,
  output logic           q_ready,
  vt4_out_if.source      results
);
  import vt4_pkg::*;

  localparam int PROD_W = 2 * COMP_W;
  localparam int SUM_W = PROD_W + 2;
  localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRAC_BITS;
  localparam logic signed [COMP_W-1:0] MAX_VAL = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic signed [COMP_W-1:0] MIN_VAL = {1'b1, {(COMP_W-1){1'b0}}};

  logic signed [COMP_W-1:0] mat [NUM_COMP][NUM_COMP];
  logic signed [PROD_W-1:0] prod [NUM_COMP][NUM_COMP];
  logic signed [SUM_W-1:0]  sum [NUM_COMP];
  logic                     prod_valid;
  logic                     sum_valid;
  logic                     en;
  logic                     take;
  logic signed [SUM_W-1:0]  shifted [NUM_COMP];
  logic signed [COMP_W-1:0] clipped [NUM_COMP];
  logic [NUM_COMP-1:0]      clip;

  assign en = !results.valid || results.ready;
  assign q_ready = en;
  assign take = q_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_COMP; r++) begin
        for (int c = 0; c < NUM_COMP; c++) begin
          mat[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (take && q_item.is_load) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        mat[q_item.row][c] <= q_item.comp[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_COMP; r++) begin
        for (int c = 0; c < NUM_COMP; c++) begin
          prod[r][c] <= mat[r][c] * $signed(q_item.comp[c]);
        end
        sum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1])
                + SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_COMP; r++) begin
      shifted[r] = sum[r] >>> FRAC_BITS;
      if ((&shifted[r][SUM_W-1:COMP_W-1]) || !(|shifted[r][SUM_W-1:COMP_W-1])) begin
        clipped[r] = shifted[r][COMP_W-1:0];
        clip[r] = 1'b0;
      end else begin
        clipped[r] = shifted[r][SUM_W-1] ? MIN_VAL : MAX_VAL;
        clip[r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.out_x     <= clipped[0];
      results.out_y     <= clipped[1];
      results.out_z     <= clipped[2];
      results.out_w     <= clipped[3];
      results.saturated <= |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid    <= 1'b0;
      sum_valid     <= 1'b0;
      results.valid <= 1'b0;
    end else if (en) begin
      prod_valid    <= take && !q_item.is_load;
      sum_valid     <= prod_valid;
      results.valid <= sum_valid;
    end
  end

endmodule

[sim/vt4_scoreboard.sv]
// Scoreboard package for the vertex transform testbench: item and vertex types plus
// a class that tracks the matrix, predicts each transform and checks the results.
// Depends on vt4_pkg.
package vt4_tb_pkg;
  import vt4_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef struct packed {
    logic kind;
    logic [1:0] row;
    logic [NUM_COMP-1:0][COMP_W-1:0] comp;
  } vec_item_t;

  typedef struct packed {
    logic [NUM_COMP-1:0][COMP_W-1:0] comp;
    logic sat;
  } vertex_t;

  class vertex_checker;
    logic [COMP_W-1:0] matrix [NUM_COMP*NUM_COMP];
    vertex_t pending_vertices[$];
    int fails;
    int loads;
    int xforms;
    int vertices_seen;
    int clipped;

    function new();
      for (int i = 0; i < NUM_COMP * NUM_COMP; i++) begin
        matrix[i] = (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
      end
      fails = 0;
      loads = 0;
      xforms = 0;
      vertices_seen = 0;
      clipped = 0;
    endfunction

    function vertex_t apply_matrix(vec_item_t it);
      vertex_t res;
      logic signed [65:0] acc;
      logic signed [65:0] shifted;
      logic signed [63:0] prod;
      res.sat = 1'b0;
      for (int r = 0; r < NUM_COMP; r++) begin
        acc = '0;
        for (int j = 0; j < NUM_COMP; j++) begin
          prod = $signed(matrix[r * NUM_COMP + j]) * $signed(it.comp[j]);
          acc = acc + prod;
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > SAT_HI) begin
          res.comp[r] = 32'h7FFF_FFFF;
          res.sat = 1'b1;
        end else if (shifted < SAT_LO) begin
          res.comp[r] = 32'h8000_0000;
          res.sat = 1'b1;
        end else begin
          res.comp[r] = shifted[31:0];
        end
      end
      return res;
    endfunction

    function void accept_item(vec_item_t it);
      if (it.kind == KIND_LOAD) begin
        for (int j = 0; j < NUM_COMP; j++) begin
          matrix[int'(it.row) * NUM_COMP + j] = it.comp[j];
        end
        loads++;
      end else begin
        pending_vertices.push_back(apply_matrix(it));
        xforms++;
      end
    endfunction

    task report(string msg);
      if (fails < 40) begin
        $display("vt4 check failed: %s", msg);
      end
      fails++;
    endtask

    task check_vertex(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        report("result arrived with no transform outstanding");
        return;
      end
      want = pending_vertices.pop_front();
      vertices_seen++;
      if (want.sat) begin
        clipped++;
      end
      for (int k = 0; k < NUM_COMP; k++) begin
        if (got.comp[k] !== want.comp[k]) begin
          report($sformatf("vertex %0d component %0d: got %h, want %h",
                           vertices_seen, k, got.comp[k], want.comp[k]));
        end
      end
      if (got.sat !== want.sat) begin
        report($sformatf("vertex %0d saturated flag: got %b, want %b",
                         vertices_seen, got.sat, want.sat));
      end
    endtask

    function int pending();
      return pending_vertices.size();
    endfunction
  endclass
endpackage

[sim/testbench.sv]
// Testbench for vertex_transform_4x4: directed and random loads and transforms under
// several idle and stall patterns, checked against a matrix predictor.
// Depends on vt4_pkg, vt4_in_if, vt4_out_if, the block itself and vt4_tb_pkg.
module testbench;
  import vt4_pkg::*;
  import vt4_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [31:0] HALF = 32'h0000_8000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

  logic clk;
  logic rst;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;
  vertex_checker sb;

  vt4_in_if items_ch();
  vt4_out_if results_ch();

  vertex_transform_4x4 #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic vec_item_t mk(logic kind, logic [1:0] row, logic [31:0] x,
                                   logic [31:0] y, logic [31:0] z, logic [31:0] w);
    vec_item_t it;
    it.kind = kind;
    it.row = row;
    it.comp[0] = x;
    it.comp[1] = y;
    it.comp[2] = z;
    it.comp[3] = w;
    return it;
  endfunction

  function automatic logic [31:0] rand_comp();
    int v;
    case ($urandom_range(9))
      0, 1, 2: v = int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      3, 4: v = $urandom();
      5: begin
        case ($urandom_range(6))
          0: v = MAXV;
          1: v = MINV;
          2: v = 0;
          3: v = ALL1;
          4: v = 1;
          5: v = ONE;
          default: v = NEG_ONE;
        endcase
      end
      default: v = int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic vec_item_t rand_item(logic kind);
    return mk(kind, 2'($urandom_range(3)), rand_comp(), rand_comp(), rand_comp(),
              rand_comp());
  endfunction

  task automatic send(vec_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.kind <= it.kind;
    items_ch.row_index <= it.row;
    items_ch.comp_x <= it.comp[0];
    items_ch.comp_y <= it.comp[1];
    items_ch.comp_z <= it.comp[2];
    items_ch.comp_w <= it.comp[3];
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int sent;
    int nloads;
    int nxforms;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        send(rand_item(logic'($urandom_range(1))));
        sent++;
      end else begin
        nloads = $urandom_range(0, 4);
        nxforms = $urandom_range(1, 8);
        for (int i = 0; i < nloads; i++) begin
          send(rand_item(KIND_LOAD));
          sent++;
        end
        for (int i = 0; i < nxforms; i++) begin
          send(rand_item(KIND_XFORM));
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    vec_item_t it;
    vertex_t got;
    if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        it.kind = items_ch.kind;
        it.row = items_ch.row_index;
        it.comp[0] = items_ch.comp_x;
        it.comp[1] = items_ch.comp_y;
        it.comp[2] = items_ch.comp_z;
        it.comp[3] = items_ch.comp_w;
        sb.accept_item(it);
      end
      if (results_ch.valid && results_ch.ready) begin
        got.comp[0] = results_ch.out_x;
        got.comp[1] = results_ch.out_y;
        got.comp[2] = results_ch.out_z;
        got.comp[3] = results_ch.out_w;
        got.sat = results_ch.saturated;
        sb.check_vertex(got);
      end
    end
  end

  initial begin
    results_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d vertices outstanding.",
             cycle_count, sb.pending());
    $display("vertex_transform_4x4: mismatch");
    $finish;
  end

  initial begin
    vec_item_t directed[$];
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst <= 1'b1;
    items_ch.valid <= 1'b0;
    items_ch.kind <= KIND_LOAD;
    items_ch.row_index <= 2'd0;
    items_ch.comp_x <= '0;
    items_ch.comp_y <= '0;
    items_ch.comp_z <= '0;
    items_ch.comp_w <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(mk(KIND_XFORM, 2'd0, ONE, NEG_ONE, MAXV, MINV));
    directed.push_back(mk(KIND_XFORM, 2'd3, 0, 0, 0, 0));
    directed.push_back(mk(KIND_XFORM, 2'd1, ALL1, 1, HALF, 32'h1234_5678));
    directed.push_back(mk(KIND_LOAD, 2'd0, MAXV, MAXV, MAXV, MAXV));
    directed.push_back(mk(KIND_LOAD, 2'd1, MINV, MINV, MINV, MINV));
    directed.push_back(mk(KIND_LOAD, 2'd2, ALL1, ALL1, ALL1, ALL1));
    directed.push_back(mk(KIND_LOAD, 2'd3, NEG_ONE, ONE, HALF, 0));
    directed.push_back(mk(KIND_XFORM, 2'd0, MAXV, MAXV, MAXV, MAXV));
    directed.push_back(mk(KIND_XFORM, 2'd0, MINV, MINV, MINV, MINV));
    directed.push_back(mk(KIND_XFORM, 2'd0, 1, 1, 1, 1));
    directed.push_back(mk(KIND_XFORM, 2'd0, ALL1, ALL1, ALL1, ALL1));
    directed.push_back(mk(KIND_XFORM, 2'd0, MAXV, MINV, MAXV, MINV));
    directed.push_back(mk(KIND_LOAD, 2'd0, HALF, HALF, HALF, HALF));
    directed.push_back(mk(KIND_LOAD, 2'd1, 1, 0, 0, 1));
    directed.push_back(mk(KIND_LOAD, 2'd2, ONE, 0, 0, 0));
    directed.push_back(mk(KIND_LOAD, 2'd3, 0, 0, 0, ONE));
    directed.push_back(mk(KIND_XFORM, 2'd2, 1, 1, 1, 1));
    directed.push_back(mk(KIND_XFORM, 2'd2, ALL1, ALL1, ALL1, ALL1));
    directed.push_back(mk(KIND_XFORM, 2'd2, MAXV, MAXV, MAXV, MAXV));
    directed.push_back(mk(KIND_XFORM, 2'd1, ONE, NEG_ONE, 32'h0003_0000, MINV));
    directed.push_back(mk(KIND_LOAD, 2'd0, ONE, 0, 0, 0));
    directed.push_back(mk(KIND_LOAD, 2'd1, 0, ONE, 0, 0));
    directed.push_back(mk(KIND_LOAD, 2'd2, 0, 0, ONE, 0));
    directed.push_back(mk(KIND_LOAD, 2'd3, 0, 0, 0, ONE));
    directed.push_back(mk(KIND_XFORM, 2'd3, MAXV, MINV, 1, ALL1));
    foreach (directed[i]) begin
      send(directed[i]);
    end

    run_random(260);
    send_idle_pct = 83;
    run_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_random(200);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    run_random(240);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    run_random(150);
    items_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Covered %0d items (%0d row loads, %0d transforms) in five pacing phases.",
             sb.loads + sb.xforms, sb.loads, sb.xforms);
    $display("Checked %0d vertices, %0d of them clipped; %0d mismatches.",
             sb.vertices_seen, sb.clipped, sb.fails);
    if (sb.fails == 0) begin
      $display("vertex_transform_4x4: match");
    end else begin
      $display("vertex_transform_4x4: mismatch");
    end
    $finish;
  end
endmodule
